FILE: design/fct_pkg.sv
package fct_pkg;

    // Result status codes
    localparam logic [1:0] ST_FETCH = 2'd0;
    localparam logic [1:0] ST_DATA  = 2'd1;
    localparam logic [1:0] ST_END   = 2'd2;
    localparam logic [1:0] ST_UNEXP = 2'd3;

    // FAT entry width codes (code 3 behaves as FAT32)
    localparam logic [1:0] FAT12 = 2'd0;
    localparam logic [1:0] FAT16 = 2'd1;
    localparam logic [1:0] FAT32 = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_FAT_KIND   = 3'd0;
    localparam logic [2:0] CFG_RESERVED   = 3'd1;
    localparam logic [2:0] CFG_SHIFT      = 3'd2;
    localparam logic [2:0] CFG_DATA_START = 3'd3;
    localparam logic [2:0] CFG_ROOT_START = 3'd4;
    localparam logic [2:0] CFG_ROOT_COUNT = 3'd5;

    // End-of-chain thresholds
    localparam logic [11:0] FAT12_EOC = 12'hff8;
    localparam logic [15:0] FAT16_EOC = 16'hfff8;
    localparam logic [27:0] FAT32_EOC = 28'hffffff8;

    localparam int SECTOR_BITS = 9;

    typedef struct packed {
        logic [1:0]  fat_kind;
        logic [15:0] reserved_sectors;
        logic [2:0]  cluster_shift;
        logic [31:0] data_start_sector;
        logic [31:0] root_start_sector;
        logic [12:0] root_sector_count;
    } cfg_t;

    typedef struct packed {
        logic [27:0] current_cluster;
        logic [22:0] hops_left;
        logic [6:0]  sector_within_cluster;
        logic        awaiting_word;
    } walk_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] sector_number;
        logic [8:0]  byte_in_sector;
    } result_t;

endpackage

FILE: design/fct_step.sv
module fct_step
(
    input  logic               mode,
    input  logic [27:0]        start_cluster,
    input  logic               in_root,
    input  logic [31:0]        byte_offset_in_file,
    input  logic [31:0]        fat_word,
    input  fct_pkg::cfg_t      cfg,
    input  fct_pkg::walk_t     walk,
    output fct_pkg::walk_t     walk_next,
    output fct_pkg::result_t   result
);

    logic [22:0] start_hops;
    logic [6:0]  start_swc;
    logic [11:0] v12;
    logic [27:0] decoded;
    logic [27:0] cur;
    logic [22:0] hops;
    logic [6:0]  swc;
    logic [29:0] fat_off;
    logic [31:0] fetch_sector;
    logic [31:0] data_sector;
    logic        root_past_end;

    // Split the offset into whole clusters and the sector inside one
    assign start_hops = byte_offset_in_file[31:9] >> cfg.cluster_shift;
    assign start_swc  = byte_offset_in_file[15:9] & ~(7'(7'h7f << cfg.cluster_shift));

    // Decode the FAT entry; end markers fold into zero
    always_comb
    begin
        v12 = walk.current_cluster[0] ? fat_word[15:4] : fat_word[11:0];
        case (cfg.fat_kind)
            fct_pkg::FAT12:
                decoded = (v12 >= fct_pkg::FAT12_EOC) ? 28'd0 : 28'(v12);
            fct_pkg::FAT16:
                decoded = (fat_word[15:0] >= fct_pkg::FAT16_EOC) ? 28'd0
                        : 28'(fat_word[15:0]);
            default:
                decoded = (fat_word[27:0] >= fct_pkg::FAT32_EOC) ? 28'd0
                        : fat_word[27:0];
        endcase
    end

    // Cluster state after this item
    assign cur  = mode ? decoded : start_cluster;
    assign hops = mode ? (walk.hops_left - 23'd1) : start_hops;
    assign swc  = mode ? walk.sector_within_cluster : start_swc;

    // FAT byte offset of the entry for cur
    always_comb
    begin
        case (cfg.fat_kind)
            fct_pkg::FAT12: fat_off = 30'(cur) + 30'(cur >> 1);
            fct_pkg::FAT16: fat_off = {1'b0, cur, 1'b0};
            default:        fat_off = {cur, 2'b00};
        endcase
    end

    assign fetch_sector = 32'(cfg.reserved_sectors) + 32'(fat_off[29:fct_pkg::SECTOR_BITS]);
    assign data_sector  = ((32'(cur) - 32'd2) << cfg.cluster_shift)
                        + cfg.data_start_sector + 32'(swc);
    assign root_past_end = byte_offset_in_file >= 32'({cfg.root_sector_count, 9'd0});

    // Result and next state
    always_comb
    begin
        walk_next = walk;
        result    = '0;
        if (!mode && in_root)
        begin
            walk_next.awaiting_word = 1'b0;
            if (root_past_end)
                result.status = fct_pkg::ST_END;
            else
            begin
                result.status        = fct_pkg::ST_DATA;
                result.sector_number = cfg.root_start_sector
                                     + 32'(byte_offset_in_file[31:9]);
            end
        end
        else if (mode && !walk.awaiting_word)
        begin
            result.status = fct_pkg::ST_UNEXP;
        end
        else
        begin
            walk_next.current_cluster       = cur;
            walk_next.hops_left             = hops;
            walk_next.sector_within_cluster = swc;
            walk_next.awaiting_word         = 1'b0;
            if (cur == 28'd0)
                result.status = fct_pkg::ST_END;
            else if (hops == 23'd0)
            begin
                result.status        = fct_pkg::ST_DATA;
                result.sector_number = data_sector;
            end
            else
            begin
                walk_next.awaiting_word = 1'b1;
                result.status           = fct_pkg::ST_FETCH;
                result.sector_number    = fetch_sector;
                result.byte_in_sector   = fat_off[8:0];
            end
        end
    end

endmodule

FILE: design/fat_cluster_chain_translator_top.sv
// FAT cluster chain translator. Start items (mode 0) turn a file byte offset
// into a sector: the fixed root directory answers at once, other files either
// answer at once or ask for a FAT fetch (status 0, sector and byte of the
// entry). Each FAT word item (mode 1) answers the last fetch and yields the
// next fetch, the data sector, or an end status; with no fetch pending it
// gives the unexpected status. Every item gives exactly one result; one item
// is taken per clock while in_stall is low. Results enter a two-entry buffer:
// the result register, or the skid register while the output stalls. in_stall
// rises only when that skid register is occupied. Configuration writes take
// effect at once and must be made only while no item is in flight.
module fat_cluster_chain_translator_top
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [27:0] start_cluster,
    input  logic        in_root,
    input  logic [31:0] byte_offset_in_file,
    input  logic [31:0] fat_word,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] sector_number,
    output logic [8:0]  byte_in_sector
);

    fct_pkg::cfg_t    cfg_reg;
    fct_pkg::walk_t   walk_reg;
    fct_pkg::walk_t   walk_next;
    fct_pkg::result_t new_result;
    fct_pkg::result_t out_reg;
    fct_pkg::result_t skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             accept;
    logic             take;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign take     = out_valid_reg && !out_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fat_kind          <= fct_pkg::FAT16;
            cfg_reg.reserved_sectors  <= 16'd1;
            cfg_reg.cluster_shift     <= 3'd0;
            cfg_reg.data_start_sector <= 32'd0;
            cfg_reg.root_start_sector <= 32'd0;
            cfg_reg.root_sector_count <= 13'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fct_pkg::CFG_FAT_KIND:   cfg_reg.fat_kind          <= cfg_data[1:0];
                fct_pkg::CFG_RESERVED:   cfg_reg.reserved_sectors  <= cfg_data[15:0];
                fct_pkg::CFG_SHIFT:      cfg_reg.cluster_shift     <= cfg_data[2:0];
                fct_pkg::CFG_DATA_START: cfg_reg.data_start_sector <= cfg_data;
                fct_pkg::CFG_ROOT_START: cfg_reg.root_start_sector <= cfg_data;
                fct_pkg::CFG_ROOT_COUNT: cfg_reg.root_sector_count <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    fct_step u_step
    (
        .mode                (mode),
        .start_cluster       (start_cluster),
        .in_root             (in_root),
        .byte_offset_in_file (byte_offset_in_file),
        .fat_word            (fat_word),
        .cfg                 (cfg_reg),
        .walk                (walk_reg),
        .walk_next           (walk_next),
        .result              (new_result)
    );

    // Walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            walk_reg <= '0;
        else if (accept)
            walk_reg <= walk_next;
    end

    // Output register and skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= accept;
        end
        else if (accept)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= new_result;
        end
        else if (accept)
            skid_reg <= new_result;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_reg.status;
    assign sector_number  = out_reg.sector_number;
    assign byte_in_sector = out_reg.byte_in_sector;

    // Checks
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_fetch_arms_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && new_result.status == fct_pkg::ST_FETCH) |=> walk_reg.awaiting_word)
        else $error("fetch issued without waiting for a FAT word");

    a_other_clears_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && new_result.status != fct_pkg::ST_FETCH) |=> !walk_reg.awaiting_word)
        else $error("still waiting for a FAT word after a non-fetch result");

endmodule

FILE: bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Item kinds carried on the mode field
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_WORD  = 1'b1;
    // Spare entry width code, decoded as FAT32
    localparam logic [1:0] FAT_KIND_SPARE = 2'd3;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [27:0] start_cluster;
    logic        in_root;
    logic [31:0] byte_offset_in_file;
    logic [31:0] fat_word;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [31:0] sector_number;
    logic [8:0]  byte_in_sector;

    fat_cluster_chain_translator_top u_top
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write           (cfg_write),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .mode                (mode),
        .start_cluster       (start_cluster),
        .in_root             (in_root),
        .byte_offset_in_file (byte_offset_in_file),
        .fat_word            (fat_word),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .status              (status),
        .sector_number       (sector_number),
        .byte_in_sector      (byte_in_sector)
    );

    // Translator copy: registers and walk state, updated at the sampling edge
    logic [1:0]  k_fat_kind;
    logic [15:0] k_reserved;
    logic [2:0]  k_shift;
    logic [31:0] k_data_start;
    logic [31:0] k_root_start;
    logic [12:0] k_root_count;
    fct_pkg::walk_t walk;

    fct_pkg::result_t expected_translations[$];

    // Stimulus side view of the current settings
    logic [1:0]  gen_kind;
    logic [2:0]  gen_shift;
    logic [12:0] gen_root_count;

    int send_idle_pct;
    int recv_stall_pct;
    int n_sent;
    int n_checked;
    int n_settings;
    int n_errors;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles, %0d results still pending",
                 CYCLE_LIMIT, expected_translations.size());
        $display("FAILURE");
        $finish;
    end

    // Receiver back-pressure
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall = rst_n && ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Expected result of one accepted item; advances the walk state
    function automatic fct_pkg::result_t translate_item(input logic md,
                                                        input logic [27:0] sc,
                                                        input logic rt,
                                                        input logic [31:0] off,
                                                        input logic [31:0] w);
        fct_pkg::result_t r;
        logic [31:0] c32;
        logic [31:0] fat_off;
        logic [11:0] v12;
        logic [27:0] nxt;
        r = '0;
        if (md == MODE_START)
        begin
            walk.awaiting_word = 1'b0;
            // fixed root: plain offset, bounded by the root size
            if (rt)
            begin
                if (off >= ({19'b0, k_root_count} << 9))
                    r.status = fct_pkg::ST_END;
                else
                begin
                    r.status = fct_pkg::ST_DATA;
                    r.sector_number = k_root_start + (off >> 9);
                end
                return r;
            end
            walk.current_cluster = sc;
            walk.hops_left = off[31:9] >> k_shift;
            walk.sector_within_cluster = off[15:9] & ((7'd1 << k_shift) - 7'd1);
        end
        else
        begin
            if (!walk.awaiting_word)
            begin
                r.status = fct_pkg::ST_UNEXP;
                return r;
            end
            // decode the FAT entry; end markers and free entries become zero
            case (k_fat_kind)
                fct_pkg::FAT12:
                begin
                    v12 = walk.current_cluster[0] ? w[15:4] : w[11:0];
                    nxt = (v12 >= fct_pkg::FAT12_EOC) ? 28'd0 : {16'b0, v12};
                end
                fct_pkg::FAT16:
                    nxt = (w[15:0] >= fct_pkg::FAT16_EOC) ? 28'd0 : {12'b0, w[15:0]};
                default:
                    nxt = (w[27:0] >= fct_pkg::FAT32_EOC) ? 28'd0 : w[27:0];
            endcase
            walk.current_cluster = nxt;
            walk.hops_left = walk.hops_left - 23'd1;
        end

        c32 = {4'b0, walk.current_cluster};
        if (walk.current_cluster == 28'd0)
        begin
            walk.awaiting_word = 1'b0;
            r.status = fct_pkg::ST_END;
        end
        else if (walk.hops_left == 23'd0)
        begin
            walk.awaiting_word = 1'b0;
            r.status = fct_pkg::ST_DATA;
            r.sector_number = ((c32 - 32'd2) << k_shift) + k_data_start
                              + {25'b0, walk.sector_within_cluster};
        end
        else
        begin
            case (k_fat_kind)
                fct_pkg::FAT12: fat_off = c32 + (c32 >> 1);
                fct_pkg::FAT16: fat_off = c32 << 1;
                default:        fat_off = c32 << 2;
            endcase
            walk.awaiting_word = 1'b1;
            r.status = fct_pkg::ST_FETCH;
            r.sector_number = {16'b0, k_reserved} + (fat_off >> 9);
            r.byte_in_sector = fat_off[8:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        $display("ERROR at %0t, result %0d: %s got %h expected %h",
                 $time, n_checked, what, got, want);
    endtask

    // Register writes, accepted items and finished results, all at the rising edge
    always @(posedge clk)
    begin : scoreboard
        fct_pkg::result_t exp_r;
        if (!rst_n)
        begin
            k_fat_kind   = fct_pkg::FAT16;
            k_reserved   = 16'd1;
            k_shift      = 3'd0;
            k_data_start = 32'd0;
            k_root_start = 32'd0;
            k_root_count = 13'd0;
            walk         = '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    fct_pkg::CFG_FAT_KIND:   k_fat_kind   = cfg_data[1:0];
                    fct_pkg::CFG_RESERVED:   k_reserved   = cfg_data[15:0];
                    fct_pkg::CFG_SHIFT:      k_shift      = cfg_data[2:0];
                    fct_pkg::CFG_DATA_START: k_data_start = cfg_data;
                    fct_pkg::CFG_ROOT_START: k_root_start = cfg_data;
                    fct_pkg::CFG_ROOT_COUNT: k_root_count = cfg_data[12:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_translations.push_back(translate_item(mode, start_cluster, in_root,
                                                               byte_offset_in_file, fat_word));
            if (out_valid && !out_stall)
            begin
                if (expected_translations.size() == 0)
                    report_mismatch("result with nothing pending, status", {30'b0, status},
                                    32'd0);
                else
                begin
                    exp_r = expected_translations.pop_front();
                    n_checked++;
                    if (status !== exp_r.status)
                        report_mismatch("status", {30'b0, status}, {30'b0, exp_r.status});
                    if (sector_number !== exp_r.sector_number)
                        report_mismatch("sector_number", sector_number, exp_r.sector_number);
                    if (byte_in_sector !== exp_r.byte_in_sector)
                        report_mismatch("byte_in_sector", {23'b0, byte_in_sector},
                                        {23'b0, exp_r.byte_in_sector});
                end
            end
        end
    end

    // Present one item after a random idle gap and hold it until taken
    task automatic send_item(input logic md, input logic [27:0] sc, input logic rt,
                             input logic [31:0] off, input logic [31:0] w);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        mode = md;
        start_cluster = sc;
        in_root = rt;
        byte_offset_in_file = off;
        fat_word = w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_sent++;
    endtask

    task automatic send_start(input logic [27:0] sc, input logic [31:0] off);
        send_item(MODE_START, sc, 1'b0, off, $urandom);
    endtask

    task automatic send_root(input logic [31:0] off);
        send_item(MODE_START, 28'($urandom), 1'b1, off, $urandom);
    endtask

    task automatic send_word(input logic [31:0] w);
        send_item(MODE_WORD, 28'($urandom), 1'($urandom_range(1)), $urandom, w);
    endtask

    // Drop valid and let every pending result come out
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_translations.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = value;
    endtask

    task automatic set_config(input logic [1:0] kind, input logic [15:0] rsv,
                              input logic [2:0] sh, input logic [31:0] ds,
                              input logic [31:0] rs, input logic [12:0] rc);
        wait_idle();
        write_reg(fct_pkg::CFG_FAT_KIND, {30'b0, kind});
        write_reg(fct_pkg::CFG_RESERVED, {16'b0, rsv});
        write_reg(fct_pkg::CFG_SHIFT, {29'b0, sh});
        write_reg(fct_pkg::CFG_DATA_START, ds);
        write_reg(fct_pkg::CFG_ROOT_START, rs);
        write_reg(fct_pkg::CFG_ROOT_COUNT, {19'b0, rc});
        @(negedge clk);
        cfg_write = 1'b0;
        gen_kind = kind;
        gen_shift = sh;
        gen_root_count = rc;
        n_settings++;
    endtask

    // FAT word holding entry v for a cluster of the given parity; other bits random
    function automatic logic [31:0] encode_entry(input logic [1:0] kind, input logic odd,
                                                 input logic [27:0] v);
        logic [31:0] w;
        w = $urandom;
        case (kind)
            fct_pkg::FAT12:
                if (odd)
                    w[15:4] = v[11:0];
                else
                    w[11:0] = v[11:0];
            fct_pkg::FAT16: w[15:0] = v[15:0];
            default:        w[27:0] = v;
        endcase
        return w;
    endfunction

    // Mostly complete chain walks with random clusters, plus root reads and noise
    task automatic run_file_walks(input int count);
        int          target;
        int          pick;
        int          hops;
        int          h;
        logic [27:0] cur;
        logic [27:0] nxt;
        logic [27:0] top;
        logic [31:0] off;
        logic [31:0] lim;
        target = n_sent + count;
        top = (gen_kind == fct_pkg::FAT12) ? 28'hff7
            : (gen_kind == fct_pkg::FAT16) ? 28'hfff7 : 28'hffffff7;
        while (n_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_word($urandom);
            else if (pick < 18)
            begin
                // root reads, half of them right around the end of the root
                lim = {19'b0, gen_root_count} << 9;
                if ($urandom_range(1))
                    send_root($urandom);
                else
                    send_root(lim + $urandom_range(2) - 32'd1);
            end
            else if (pick < 23)
                send_start(($urandom_range(3) == 0) ? 28'd0 : 28'($urandom), $urandom);
            else
            begin
                pick = $urandom_range(99);
                if (pick < 3)
                    cur = 28'd1;
                else if (pick < 15)
                    cur = 28'($urandom_range(1, 28'hfffffff));
                else
                    cur = 28'($urandom_range(2, 4000));
                hops = ($urandom_range(3) != 0) ? $urandom_range(3) : $urandom_range(4, 10);
                off = (32'(hops) << (9 + gen_shift))
                      | ($urandom & ((32'd1 << (9 + gen_shift)) - 32'd1));
                send_start(cur, off);
                for (h = 0; h < hops; h++)
                begin
                    pick = $urandom_range(99);
                    // walk abandoned: the next start drops it
                    if (pick < 4)
                        break;
                    // chain ends early on a free entry or an end marker
                    if (pick < 10)
                    begin
                        nxt = $urandom_range(1) ? 28'd0 : top + 28'($urandom_range(1, 8));
                        send_word(encode_entry(gen_kind, cur[0], nxt));
                        break;
                    end
                    if ($urandom_range(2) == 0)
                        nxt = 28'($urandom_range(1, top));
                    else
                        nxt = 28'($urandom_range(1, 4000));
                    send_word(encode_entry(gen_kind, cur[0], nxt));
                    cur = nxt;
                end
            end
        end
    endtask

    // Reset settings: word while idle, direct hits, a restarted walk, FAT16 end marker
    task automatic test_reset_state();
        send_word(32'h0000_0003);
        send_start(28'd5, 32'd0);
        send_start(28'd0, 32'h0000_0400);
        send_start(28'hfffffff, 32'd512);
        send_word(32'hffff_0003);
        send_start(28'd6, 32'd1024);
        send_start(28'd9, 32'd100);
        send_word(32'h1234_5678);
        send_start(28'd7, 32'd512);
        send_word(32'h0000_fff8);
    endtask

    // Fixed root under FAT32 settings, inside and past the end
    task automatic test_root_directory();
        set_config(fct_pkg::FAT32, 16'd1, 3'd2, 32'd100, 32'hffff_fff0, 13'd4);
        send_root(32'd0);
        send_root(32'd2047);
        send_root(32'd2048);
        send_root(32'hffff_ffff);
    endtask

    // FAT12 odd and even entries, cluster one wrapping, end marker, empty root
    task automatic test_fat12_chain();
        set_config(fct_pkg::FAT12, 16'hffff, 3'd0, 32'hffff_ffff, 32'd0, 13'd0);
        send_start(28'd3, 32'd1536);
        send_word(32'hdead_004f);
        send_word(32'h1234_fff7);
        send_word(32'h0000_0010);
        send_start(28'd2, 32'd512);
        send_word(32'h0000_0ff8);
        send_root(32'd0);
    endtask

    // FAT32 and the spare width code: top cluster, end marker, free entry, shift 7
    task automatic test_fat32_chain();
        set_config(fct_pkg::FAT32, 16'd0, 3'd7, 32'd0, 32'd0, 13'd4096);
        send_start(28'hfffffff, 32'h0001_0000);
        send_word(32'hffff_fff8);
        send_start(28'd2, 32'h0001_0000);
        send_word(32'h0000_0000);
        set_config(FAT_KIND_SPARE, 16'd300, 3'd7, 32'h8000_0000, 32'd0, 13'd4096);
        send_start(28'd10, 32'h0002_0a07);
        send_word(32'hf000_0020);
        send_word(32'hffff_fff7);
    endtask

    // Random walks over four idling phases, two settings each
    task automatic test_random_walks();
        int p;
        int s;
        for (p = 0; p < 4; p++)
        begin
            for (s = 0; s < 2; s++)
            begin
                if (p == 0 && s == 0)
                    set_config(fct_pkg::FAT12, 16'd0, 3'd0, 32'd0, 32'd0, 13'd0);
                else if (p == 0)
                    set_config(fct_pkg::FAT32, 16'hffff, 3'd7, 32'hffff_ffff,
                               32'hffff_ffff, 13'd4096);
                else
                    set_config(2'($urandom_range(3)),
                               ($urandom_range(3) == 0) ? 16'hffff : 16'($urandom),
                               3'($urandom_range(7)), $urandom, $urandom,
                               13'($urandom_range(4096)));
                send_idle_pct  = (p == 1) ? 69 : (p == 3) ? 16 : 0;
                recv_stall_pct = (p == 2) ? 69 : (p == 3) ? 16 : 0;
                run_file_walks(220);
            end
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = fct_pkg::CFG_FAT_KIND;
        cfg_data = 32'd0;
        in_valid = 1'b0;
        mode = MODE_START;
        start_cluster = 28'd0;
        in_root = 1'b0;
        byte_offset_in_file = 32'd0;
        fat_word = 32'd0;
        gen_kind = fct_pkg::FAT16;
        gen_shift = 3'd0;
        gen_root_count = 13'd0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        n_sent = 0;
        n_checked = 0;
        n_settings = 0;
        n_errors = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_root_directory();
        test_fat12_chain();
        test_fat32_chain();
        test_random_walks();
        wait_idle();

        $display("Sent %0d items (starts, root reads, FAT words), checked %0d results",
                 n_sent, n_checked);
        $display("%0d register settings, idling none/sender/receiver/both, %0d mismatches",
                 n_settings, n_errors);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
design/fct_pkg.sv
design/fct_step.sv
design/fat_cluster_chain_translator_top.sv
bench/testbench.sv
